// ===== rtl/sync_length_xor_frame_receiver_unit_defines.svh =====
// Assertion macros used by the frame receiver's output sequencer.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define SLFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define SLFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slfr_pkg.sv =====
// Shared types, constants and reply byte table of the frame receiver.
package slfr_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 4;

  localparam logic [DataW-1:0] Sync1 = 8'h55;
  localparam logic [DataW-1:0] Sync2 = 8'hAA;

  localparam logic [WordW-1:0] MaxLenReset  = 16'd1024;
  localparam logic [WordW-1:0] TimeoutReset = 16'd200;
  localparam logic [WordW-1:0] IdleSat      = 16'hFFFF;

  // Position of the final byte in a reply frame.
  localparam logic [3:0] ReplyLast = 4'd13;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMaxLen  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout = 1'd1;

  // Result kinds.
  localparam logic KindPayload = 1'b0;
  localparam logic KindReply   = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_IDH,
    PH_IDL,
    PH_LENH,
    PH_LENL,
    PH_CPLH,
    PH_CPLL,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // One request from the parser to the output sequencer.
  typedef struct packed {
    logic             kind;
    logic             ok;
    logic [DataW-1:0] data;
    logic [WordW-1:0] index;
    logic [WordW-1:0] id;
    logic [WordW-1:0] len;
  } entry_t;

  // Byte k of the reply frame AA 55 idH idL 00 05 FF FA 00 00 02 00 st cs.
  // The fixed bytes fold into a checksum seed of FD.
  function automatic logic [DataW-1:0] reply_byte(input logic [3:0] k,
                                                  input logic [WordW-1:0] id,
                                                  input logic ok);
    logic [DataW-1:0] st;
    logic [DataW-1:0] b;
    st = {7'd0, ~ok};
    case (k)
      4'd0:    b = 8'hAA;
      4'd1:    b = 8'h55;
      4'd2:    b = id[15:8];
      4'd3:    b = id[7:0];
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h05;
      4'd6:    b = 8'hFF;
      4'd7:    b = 8'hFA;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h00;
      4'd10:   b = 8'h02;
      4'd11:   b = 8'h00;
      4'd12:   b = st;
      4'd13:   b = 8'hFD ^ id[15:8] ^ id[7:0] ^ st;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/slfr_ifs.sv =====
// Valid/ready channel interfaces for received items and results.
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data;
  logic [15:0] index;
  logic        frame_ok;
  logic [15:0] frame_len;
  logic        last;

  modport source (output valid, kind, data, index, frame_ok, frame_len, last,
                  input ready);
  modport sink (input valid, kind, data, index, frame_ok, frame_len, last,
                output ready);
endinterface

// ===== rtl/slfr_fifo.sv =====
// Small request queue between the frame parser and the output sequencer.
module slfr_fifo #(
  parameter int unsigned Depth = slfr_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  slfr_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output slfr_pkg::entry_t pop_entry
);
  import slfr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the depth; count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/slfr_front.sv =====
// Frame parser: accepts bytes and idle ticks and queues payload and reply requests.
module slfr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [slfr_pkg::WordW-1:0]       max_len,
  input  logic [slfr_pkg::WordW-1:0]       timeout_ticks,
  slfr_in_if.sink                          in_ch,
  output logic                             push_valid,
  input  logic                             push_ready,
  output slfr_pkg::entry_t                 push_entry
);
  import slfr_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [DataW-1:0] running_xor;
  logic [DataW-1:0] running_xor_next;
  logic [WordW-1:0] frame_id;
  logic [WordW-1:0] frame_id_next;
  logic [WordW-1:0] length_field;
  logic [WordW-1:0] length_field_next;
  logic [WordW-1:0] complement_field;
  logic [WordW-1:0] complement_field_next;
  logic [WordW-1:0] payload_count;
  logic [WordW-1:0] payload_count_next;
  logic [WordW-1:0] idle_count;
  logic [WordW-1:0] idle_count_next;

  logic             acc;
  logic [DataW-1:0] b;
  logic [WordW-1:0] idle_inc;
  logic             timed_out;
  logic [WordW-1:0] cpl_word;
  logic             cpl_bad;
  logic             len_bad;
  logic [WordW-1:0] count_inc;

  assign in_ch.ready = push_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Frame checks shared by the next-state and output logic.
  assign idle_inc  = (idle_count == IdleSat) ? idle_count : idle_count + 16'd1;
  assign timed_out = (idle_inc > timeout_ticks);
  assign cpl_word  = {complement_field[15:8], b};
  assign cpl_bad   = (~cpl_word != length_field);
  assign len_bad   = (length_field > max_len);
  assign count_inc = payload_count + 16'd1;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (acc) begin
      if (in_ch.mode) begin
        if ((phase != PH_HUNT1) && timed_out) begin
          phase_next = PH_HUNT1;
        end
      end else begin
        case (phase)
          PH_HUNT1:   phase_next = (b == Sync1) ? PH_HUNT2 : PH_HUNT1;
          PH_HUNT2:   phase_next = (b == Sync2) ? PH_IDH : PH_HUNT1;
          PH_IDH:     phase_next = PH_IDL;
          PH_IDL:     phase_next = PH_LENH;
          PH_LENH:    phase_next = PH_LENL;
          PH_LENL:    phase_next = PH_CPLH;
          PH_CPLH:    phase_next = PH_CPLL;
          PH_CPLL: begin
            if (cpl_bad || len_bad) begin
              phase_next = PH_HUNT1;
            end else begin
              phase_next = (length_field == '0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: phase_next = (count_inc >= length_field) ? PH_CHECK : PH_PAYLOAD;
          PH_CHECK:   phase_next = PH_HUNT1;
          default:    phase_next = PH_HUNT1;
        endcase
      end
    end
  end

  // Queue requests and frame field updates.
  always_comb begin
    push_valid            = 1'b0;
    push_entry.kind       = KindReply;
    push_entry.ok         = 1'b0;
    push_entry.data       = b;
    push_entry.index      = payload_count;
    push_entry.id         = frame_id;
    push_entry.len        = '0;
    running_xor_next      = running_xor;
    frame_id_next         = frame_id;
    length_field_next     = length_field;
    complement_field_next = complement_field;
    payload_count_next    = payload_count;
    idle_count_next       = idle_count;
    if (acc) begin
      if (in_ch.mode) begin
        if (phase != PH_HUNT1) begin
          idle_count_next = idle_inc;
          if (timed_out) begin
            push_valid      = 1'b1;
            idle_count_next = '0;
          end
        end
      end else begin
        idle_count_next = '0;
        case (phase)
          PH_HUNT1: begin
            if (b == Sync1) begin
              running_xor_next = b;
            end
          end
          PH_HUNT2: begin
            if (b == Sync2) begin
              running_xor_next = running_xor ^ b;
            end
          end
          PH_IDH: begin
            running_xor_next  = running_xor ^ b;
            length_field_next = {8'd0, b};
          end
          PH_IDL: begin
            running_xor_next = running_xor ^ b;
            frame_id_next    = {length_field[7:0], b};
          end
          PH_LENH: begin
            running_xor_next  = running_xor ^ b;
            length_field_next = {b, 8'd0};
          end
          PH_LENL: begin
            running_xor_next  = running_xor ^ b;
            length_field_next = {length_field[15:8], b};
          end
          PH_CPLH: begin
            running_xor_next      = running_xor ^ b;
            complement_field_next = {b, 8'd0};
          end
          PH_CPLL: begin
            running_xor_next      = running_xor ^ b;
            complement_field_next = cpl_word;
            payload_count_next    = '0;
            // A bad complement or an oversize length rejects at once.
            if (cpl_bad || len_bad) begin
              push_valid = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            running_xor_next   = running_xor ^ b;
            push_valid         = 1'b1;
            push_entry.kind    = KindPayload;
            payload_count_next = count_inc;
          end
          PH_CHECK: begin
            push_valid    = 1'b1;
            push_entry.ok = (b == running_xor);
            if (b == running_xor) begin
              push_entry.len = length_field;
            end
          end
          default: begin
            if (b == Sync1) begin
              running_xor_next = b;
            end
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT1;
      running_xor      <= '0;
      frame_id         <= '0;
      length_field     <= '0;
      complement_field <= '0;
      payload_count    <= '0;
      idle_count       <= '0;
    end else begin
      phase            <= phase_next;
      running_xor      <= running_xor_next;
      frame_id         <= frame_id_next;
      length_field     <= length_field_next;
      complement_field <= complement_field_next;
      payload_count    <= payload_count_next;
      idle_count       <= idle_count_next;
    end
  end

endmodule

// ===== rtl/slfr_back.sv =====
// Output sequencer: turns queued requests into payload results and 14-byte replies.
`include "sync_length_xor_frame_receiver_unit_defines.svh"

module slfr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  slfr_pkg::entry_t pop_entry,
  slfr_out_if.source       out_ch
);
  import slfr_pkg::*;

  logic             out_valid;
  logic             out_kind;
  logic [DataW-1:0] out_data;
  logic [WordW-1:0] out_index;
  logic             out_ok;
  logic [WordW-1:0] out_len;
  logic             out_last;

  logic             rep_active;
  logic [3:0]       rep_k;
  entry_t           cur;

  logic             adv;
  entry_t           src;
  logic [3:0]       beat;
  logic             load;

  // The output register advances when empty or when its result is taken.
  assign adv       = !out_valid || out_ch.ready;
  assign pop_ready = adv && !rep_active;
  assign load      = adv && (rep_active || pop_valid);
  assign src       = rep_active ? cur : pop_entry;
  assign beat      = rep_active ? rep_k : 4'd0;

  // Control: output valid and reply beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      rep_active <= 1'b0;
      rep_k      <= '0;
    end else if (adv) begin
      out_valid <= load;
      if (rep_active) begin
        rep_k <= rep_k + 4'd1;
        if (rep_k == ReplyLast) begin
          rep_active <= 1'b0;
        end
      end else if (pop_valid && (pop_entry.kind == KindReply)) begin
        rep_active <= 1'b1;
        rep_k      <= 4'd1;
      end
    end
  end

  // Result payload and the held reply request.
  always_ff @(posedge clk) begin
    if (load) begin
      if (!rep_active) begin
        cur <= pop_entry;
      end
      out_kind <= src.kind;
      if (src.kind == KindReply) begin
        out_data  <= reply_byte(beat, src.id, src.ok);
        out_index <= {12'd0, beat};
        out_ok    <= src.ok;
        out_len   <= src.len;
        out_last  <= (beat == ReplyLast);
      end else begin
        out_data  <= src.data;
        out_index <= src.index;
        out_ok    <= 1'b0;
        out_len   <= '0;
        out_last  <= 1'b1;
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.kind      = out_kind;
  assign out_ch.data      = out_data;
  assign out_ch.index     = out_index;
  assign out_ch.frame_ok  = out_ok;
  assign out_ch.frame_len = out_len;
  assign out_ch.last      = out_last;

  // A reply burst owns the output until its last byte.
  `SLFR_ASSERT_IMP(a_no_pop_mid_reply, rep_active, !pop_ready, "queue popped during reply")
  `SLFR_ASSERT_IMP(a_beat_range, rep_active, (rep_k != 4'd0) && (rep_k <= ReplyLast), "bad beat")
  `SLFR_ASSERT_NEXT(a_reply_end, rep_active && adv && (rep_k == ReplyLast), !rep_active && out_valid && out_last, "reply did not end on last byte")
  `SLFR_ASSERT_IMP(a_payload_last, out_valid && (out_kind == KindPayload), out_last, "payload result without last")

endmodule

// ===== rtl/sync_length_xor_frame_receiver_unit.sv =====
// A result passes from the parser through the request queue and the output register.
// Throughput: one item per cycle; the parser stalls only when the request queue is full.
// A reply burst owns the output for its 14 bytes, one byte per cycle unless stalled.
// Header bytes and idle ticks give no result unless a bad header or timeout ends a frame.
// Synchronous active-high reset: parser hunts for sync, queue empties, registers reload.
module sync_length_xor_frame_receiver_unit #(
  parameter int unsigned QUEUE_DEPTH = slfr_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [slfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [slfr_pkg::WordW-1:0]   cfg_data,
  slfr_in_if.sink                      in_ch,
  slfr_out_if.source                   out_ch
);
  import slfr_pkg::*;

  logic [WordW-1:0] max_len;
  logic [WordW-1:0] timeout_ticks;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len       <= MaxLenReset;
      timeout_ticks <= TimeoutReset;
    end else if (cfg_wen) begin
      case (cfg_index)
        RegMaxLen:  max_len       <= cfg_data;
        RegTimeout: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  slfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .max_len       (max_len),
    .timeout_ticks (timeout_ticks),
    .in_ch         (in_ch),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  slfr_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  slfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/slfr_tb_pkg.sv =====
// Stimulus and reply status codes shared by the frame receiver testbench files.
`timescale 1ns / 1ps
package slfr_tb_pkg;

  // Input item modes.
  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  // Status byte of a reply frame.
  localparam logic [7:0] AckStatus = 8'h00;
  localparam logic [7:0] NakStatus = 8'h01;

endpackage

// ===== tb/slfr_frame_checker.sv =====
// Checker that predicts the frame receiver's results and compares them on the output channel.
`timescale 1ns / 1ps
module slfr_frame_checker
  import slfr_pkg::*;
  import slfr_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data,
  slfr_in_if                 in_ch,
  slfr_out_if                out_ch,
  output int                 fail_count,
  output int                 results_owed
);

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic [15:0] index;
    logic       ok;
    logic [15:0] flen;
    logic       last;
  } frame_result_t;

  // Results that the parser state says must still come out, oldest first.
  frame_result_t owed_results[$];

  // Parser state and register copies.
  phase_t      phase;
  logic [7:0]  xsum;
  logic [7:0]  id_hi;
  logic [15:0] cur_id;
  logic [15:0] len_word;
  logic [15:0] cpl_word;
  logic [15:0] pay_cnt;
  logic [15:0] idle_run;
  logic [15:0] lim_len;
  logic [15:0] lim_idle;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Queue the 14-byte ack or nak reply and return to hunting.
  task automatic queue_reply(input logic ok);
    logic [7:0]    frame [14];
    logic [7:0]    sum;
    frame_result_t r;
    frame = '{Sync2, Sync1, cur_id[15:8], cur_id[7:0], 8'h00, 8'h05, 8'hFF, 8'hFA,
              8'h00, 8'h00, 8'h02, 8'h00, ok ? AckStatus : NakStatus, 8'h00};
    sum = 8'h00;
    for (int k = 0; k < 13; k++) sum ^= frame[k];
    frame[13] = sum;
    for (int k = 0; k < 14; k++) begin
      r.kind  = KindReply;
      r.data  = frame[k];
      r.index = 16'(k);
      r.ok    = ok;
      r.flen  = ok ? len_word : 16'd0;
      r.last  = (k == 13);
      owed_results.push_back(r);
    end
    phase    = PH_HUNT1;
    idle_run = 16'd0;
  endtask

  // Advance the parser by one accepted request.
  task automatic parse_req(input logic mode, input logic [7:0] b);
    frame_result_t r;
    if (mode == ModeTick) begin
      if (phase == PH_HUNT1) return;
      if (idle_run != IdleSat) idle_run++;
      if (idle_run > lim_idle) queue_reply(1'b0);
      return;
    end
    idle_run = 16'd0;
    case (phase)
      PH_HUNT1: begin
        if (b == Sync1) begin
          xsum  = b;
          phase = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b == Sync2) begin
          xsum ^= b;
          phase = PH_IDH;
        end else begin
          phase = PH_HUNT1;
        end
      end
      PH_IDH: begin
        xsum ^= b;
        id_hi = b;
        phase = PH_IDL;
      end
      PH_IDL: begin
        xsum ^= b;
        cur_id = {id_hi, b};
        phase  = PH_LENH;
      end
      PH_LENH: begin
        xsum ^= b;
        len_word = {b, 8'h00};
        phase    = PH_LENL;
      end
      PH_LENL: begin
        xsum ^= b;
        len_word[7:0] = b;
        phase         = PH_CPLH;
      end
      PH_CPLH: begin
        xsum ^= b;
        cpl_word = {b, 8'h00};
        phase    = PH_CPLL;
      end
      PH_CPLL: begin
        xsum ^= b;
        cpl_word[7:0] = b;
        if ((~cpl_word != len_word) || (len_word > lim_len)) begin
          queue_reply(1'b0);
        end else begin
          pay_cnt = 16'd0;
          phase   = (len_word == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xsum ^= b;
        r.kind  = KindPayload;
        r.data  = b;
        r.index = pay_cnt;
        r.ok    = 1'b0;
        r.flen  = 16'd0;
        r.last  = 1'b1;
        owed_results.push_back(r);
        pay_cnt++;
        if (pay_cnt >= len_word) phase = PH_CHECK;
      end
      default: begin
        queue_reply(b == xsum);
      end
    endcase
  endtask

  // Track register writes and requests, then check each delivered result.
  always @(posedge clk) begin : watch
    frame_result_t want;
    if (rst) begin
      phase    = PH_HUNT1;
      xsum     = 8'h00;
      id_hi    = 8'h00;
      cur_id   = 16'd0;
      len_word = 16'd0;
      cpl_word = 16'd0;
      pay_cnt  = 16'd0;
      idle_run = 16'd0;
      lim_len  = MaxLenReset;
      lim_idle = TimeoutReset;
      owed_results.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          RegMaxLen:  lim_len  = cfg_data;
          RegTimeout: lim_idle = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) parse_req(in_ch.mode, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          note_mismatch("unexpected result data", out_ch.data, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_ch.kind !== want.kind) note_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.data !== want.data) note_mismatch("data", out_ch.data, want.data);
          if (out_ch.index !== want.index) note_mismatch("index", out_ch.index, want.index);
          if (out_ch.frame_ok !== want.ok) note_mismatch("frame_ok", out_ch.frame_ok, want.ok);
          if (out_ch.frame_len !== want.flen) begin
            note_mismatch("frame_len", out_ch.frame_len, want.flen);
          end
          if (out_ch.last !== want.last) note_mismatch("last", out_ch.last, want.last);
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== tb/sync_length_xor_frame_receiver_unit_tb.sv =====
// Testbench top: drives frames, idle ticks and register writes, and gives the verdict.
`timescale 1ns / 1ps
module sync_length_xor_frame_receiver_unit_tb;
  import slfr_pkg::*;
  import slfr_tb_pkg::*;

  localparam int StallLimit = 4000;

  typedef enum {FrameGood, FrameBadSync, FrameBadCpl, FrameBadSum, FrameStalled} frame_flaw_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WordW-1:0]   cfg_data = '0;

  int          fail_count;
  int          results_owed;
  int          send_gap_pct = 32;
  int          take_gap_pct = 88;
  int          hold_cycles = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] max_len_now = MaxLenReset;
  logic [15:0] timeout_now = TimeoutReset;

  slfr_in_if  in_ch ();
  slfr_out_if out_ch ();

  sync_length_xor_frame_receiver_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  slfr_frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #5 clk = ~clk;

  // Result receiver: random stalls, or a counted hold-off when one is asked for.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  task automatic put_req(input logic mode, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.mode    = mode;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic put_ticks(input int n);
    repeat (n) put_req(ModeTick, 8'($urandom));
  endtask

  // Hold the sender until every expected result is out and the parser has drained.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limits(input logic [15:0] len_lim, input logic [15:0] tick_lim);
    settle();
    cfg_wen   = 1'b1;
    cfg_index = RegMaxLen;
    cfg_data  = len_lim;
    @(negedge clk);
    cfg_index = RegTimeout;
    cfg_data  = tick_lim;
    @(negedge clk);
    cfg_wen     = 1'b0;
    max_len_now = len_lim;
    timeout_now = tick_lim;
  endtask

  // Send one frame, optionally with a flaw, with idle ticks that stay within the timeout.
  task automatic send_frame(input logic [15:0] fid, input logic [15:0] plen,
                            input frame_flaw_t flaw);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    logic [7:0] bad;
    int         stop;
    int         tick_cap;
    if (flaw == FrameStalled && timeout_now == IdleSat) flaw = FrameGood;
    bytes = {Sync1, Sync2, fid[15:8], fid[7:0], plen[15:8], plen[7:0],
             ~plen[15:8], ~plen[7:0]};
    if (flaw == FrameBadCpl) bytes[7 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    if (flaw == FrameBadSync) begin
      do bad = 8'($urandom); while (bad == Sync2);
      bytes = {Sync1, bad};
    end else if (flaw != FrameBadCpl && plen <= max_len_now) begin
      repeat (plen) bytes.push_back(8'($urandom));
      sum = 8'h00;
      foreach (bytes[i]) sum ^= bytes[i];
      if (flaw == FrameBadSum) sum ^= 8'($urandom_range(1, 255));
      bytes.push_back(sum);
    end
    stop     = (flaw == FrameStalled) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    tick_cap = (timeout_now < 6) ? timeout_now : 6;
    for (int i = 0; i < stop; i++) begin
      if (i > 0 && $urandom_range(9) == 0) put_ticks($urandom_range(0, tick_cap));
      put_req(ModeByte, bytes[i]);
    end
    if (flaw == FrameStalled) put_ticks(timeout_now + 1);
  endtask

  // Mostly well-formed frames with random content, plus flawed frames and noise.
  task automatic rand_traffic(input int n);
    int          target;
    int          pick;
    logic [15:0] plen;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      plen = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 24)) : 16'($urandom_range(0, 8));
      if (pick < 70) send_frame(16'($urandom), plen, FrameGood);
      else if (pick < 78) send_frame(16'($urandom), plen, FrameBadSum);
      else if (pick < 84) send_frame(16'($urandom), plen, FrameBadCpl);
      else if (pick < 88) send_frame(16'($urandom), plen, FrameBadSync);
      else if (pick < 92) send_frame(16'($urandom), plen, FrameStalled);
      else repeat ($urandom_range(1, 4)) put_req(1'($urandom_range(1)), 8'($urandom));
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.mode    = ModeByte;
    in_ch.rx_byte = 8'h00;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed frames at the reset limits: hunting ticks, id extremes and three flaws.
    put_ticks(3);
    send_frame(16'hFFFF, 16'd0, FrameGood);
    send_frame(16'h0000, 16'd3, FrameGood);
    send_frame(16'h1234, 16'd2, FrameBadSum);
    send_frame(16'hA5A5, 16'd1, FrameBadCpl);
    send_frame(16'h5A5A, 16'd0, FrameBadSync);

    // Length just over and at the limit; any idle tick times out.
    set_limits(16'd2, 16'd0);
    send_frame(16'h0F0F, 16'd3, FrameGood);
    send_frame(16'hF0F0, 16'd2, FrameGood);
    send_frame(16'h00FF, 16'd1, FrameStalled);

    // Zero length limit, then idle runs on both sides of the timeout.
    set_limits(16'd0, 16'd3);
    send_frame(16'hFF00, 16'd0, FrameGood);
    send_frame(16'h1111, 16'd1, FrameGood);
    put_req(ModeByte, Sync1);
    put_ticks(3);
    put_req(ModeByte, Sync2);
    put_ticks(4);

    // Long receiver hold-off while a full-size payload streams in.
    set_limits(16'd16, 16'd5);
    hold_cycles = 150;
    send_frame(16'($urandom), 16'd16, FrameGood);
    rand_traffic(45);

    // Sender mostly idle, receiver mostly ready, no length limit.
    send_gap_pct = 88;
    take_gap_pct = 32;
    set_limits(IdleSat, 16'd12);
    rand_traffic(45);

    // No idling; with the timeout at its top value an idle run never ends a frame.
    send_gap_pct = 0;
    take_gap_pct = 0;
    set_limits(16'd40, IdleSat);
    put_req(ModeByte, Sync1);
    put_ticks(20);
    put_req(ModeByte, 8'h00);
    rand_traffic(40);

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/slfr_pkg.sv
rtl/slfr_ifs.sv
rtl/slfr_fifo.sv
rtl/slfr_front.sv
rtl/slfr_back.sv
rtl/sync_length_xor_frame_receiver_unit.sv
tb/slfr_tb_pkg.sv
tb/slfr_frame_checker.sv
tb/sync_length_xor_frame_receiver_unit_tb.sv
